// ===== rtl/rcbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcbp_pkg
// Shared types, constants and helpers of the record column bit packer.
// ----------------------------------------------------------------------------
package rcbp_pkg;

  localparam int MAX_COLUMNS = 7;
  localparam int VAL_W       = 16;
  localparam int BYTE_W      = 8;
  localparam int DESC_W      = 49;
  localparam int COL_W       = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int BUF_W       = 23;   // 7 leftover bits plus a 16-bit column
  localparam int CNT_W       = 5;
  localparam int ITER_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESC_FIRST  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DESC_LAST   = 4'd7;

  typedef struct packed {
    logic             dec;
    logic [VAL_W-1:0] step;
    logic [VAL_W-1:0] vmax;
    logic [VAL_W-1:0] vmin;
  } col_desc_t;

  function automatic logic [CNT_W-1:0] bit_length(input logic [VAL_W-1:0] x);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (x[i]) n = CNT_W'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== rtl/record_column_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_column_bit_packer
// Packs range-offset column values of one record into bytes, MSB first.
// ----------------------------------------------------------------------------
// usage:
//   cfg port: write num_columns (index 0) and column descriptors (1..7)
//     while no column is in flight; one write per cfg_we cycle
//   in_*: one 16-bit column value per beat, columns in record order
//   out_*: packed bytes, out_tlast on the final byte of a record's last column
// sequencing:
//   one column at a time; in_tready is low from accept until its bytes
//   have been loaded into the output register
//   plain column: accept, then S_PACK, then S_EMIT loads each full byte (0 to 2
//   bytes); a closing partial byte is loaded in the last S_EMIT step
//   decimal column with step above 1: two passes of the shared 1-bit
//   restoring divider (range then value) run in S_DIV before S_PACK
// reset: column index and leftover bits clear, num_columns = 1,
//   descriptors 0, output register empty
// stall: a held output beat stops byte loading; the sequencer waits
// ----------------------------------------------------------------------------
module record_column_bit_packer
  import rcbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DESC_W-1:0]    cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [VAL_W-1:0]     in_tdata,   // column_value
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BYTE_W-1:0]    out_tdata,  // out_byte
  output logic                 out_tlast   // record_end
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PACK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [COL_W-1:0]  num_columns_r;
  col_desc_t         desc_r [MAX_COLUMNS];

  logic [1:0]        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [6:0]        pbits_r, pbits_nxt;
  logic [2:0]        pcnt_r, pcnt_nxt;
  logic              last_r, last_nxt;
  logic [VAL_W-1:0]  step_r, step_nxt;
  logic [VAL_W-1:0]  dvd_r, dvd_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              phase_r, phase_nxt;
  logic [VAL_W-1:0]  rng_q_r, rng_q_nxt;
  logic [VAL_W-1:0]  val_q_r, val_q_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  col_desc_t         cur_desc;
  logic [COL_W-1:0]  ncols_eff;
  logic              in_fire;
  logic              slot_free;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    trial_sub;
  logic [CNT_W-1:0]  width;
  logic [VAL_W:0]    vmask;
  logic [BUF_W-1:0]  shifted;
  logic [BYTE_W-1:0] padded;
  logic [BYTE_W-1:0] pmask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_columns_r <= COL_W'(1);
      for (int k = 0; k < MAX_COLUMNS; k++) desc_r[k] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_COLUMNS) begin
        num_columns_r <= cfg_wdata[COL_W-1:0];
      end else if (cfg_index >= CFG_DESC_FIRST && cfg_index <= CFG_DESC_LAST) begin
        desc_r[COL_W'(cfg_index - CFG_DESC_FIRST)] <= cfg_wdata;
      end
    end
  end

  assign cur_desc  = (col_r < COL_W'(MAX_COLUMNS)) ? desc_r[col_r] : '0;
  assign ncols_eff = (num_columns_r == '0) ? COL_W'(1) : num_columns_r;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // shared restoring divider step
  assign trial     = {rem_r, dvd_r[VAL_W-1]};
  assign trial_sub = trial - {1'b0, step_r};

  assign width   = bit_length(rng_q_r);
  assign vmask   = (17'd1 << width) - 17'd1;
  assign shifted = buf_r >> (cnt_r - CNT_W'(BYTE_W));
  assign padded  = buf_r[BYTE_W-1:0] << (4'd8 - {1'b0, cnt_r[2:0]});
  assign pmask   = (8'd1 << cnt_r[2:0]) - 8'd1;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    pbits_nxt     = pbits_r;
    pcnt_nxt      = pcnt_r;
    last_nxt      = last_r;
    step_nxt      = step_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    iter_nxt      = iter_r;
    phase_nxt     = phase_r;
    rng_q_nxt     = rng_q_r;
    val_q_nxt     = val_q_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt  = ({1'b0, col_r} + 4'd1) >= {1'b0, ncols_eff};
          step_nxt  = cur_desc.step;
          rng_q_nxt = cur_desc.vmax - cur_desc.vmin;
          val_q_nxt = in_tdata - cur_desc.vmin;
          if (cur_desc.dec && cur_desc.step > 16'd1) begin
            dvd_nxt   = cur_desc.vmax - cur_desc.vmin;
            rem_nxt   = '0;
            iter_nxt  = '0;
            phase_nxt = 1'b0;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_PACK;
          end
        end
      end
      S_DIV: begin
        if (!trial_sub[VAL_W]) begin
          rem_nxt = trial_sub[VAL_W-1:0];
          dvd_nxt = {dvd_r[VAL_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[VAL_W-1:0];
          dvd_nxt = {dvd_r[VAL_W-2:0], 1'b0};
        end
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(VAL_W - 1)) begin
          iter_nxt = '0;
          rem_nxt  = '0;
          if (!phase_r) begin
            rng_q_nxt = dvd_nxt;
            dvd_nxt   = val_q_r;
            phase_nxt = 1'b1;
          end else begin
            val_q_nxt = dvd_nxt;
            state_nxt = S_PACK;
          end
        end
      end
      S_PACK: begin
        buf_nxt   = (BUF_W'(pbits_r) << width) |
                    BUF_W'({1'b0, val_q_r} & vmask);
        cnt_nxt   = CNT_W'(pcnt_r) + width;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (cnt_r >= CNT_W'(BYTE_W)) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = shifted[BYTE_W-1:0];
            out_last_nxt  = last_r && (cnt_r == CNT_W'(BYTE_W));
            cnt_nxt       = cnt_r - CNT_W'(BYTE_W);
          end
        end else if (last_r) begin
          if (cnt_r == '0 || slot_free) begin
            if (cnt_r != '0) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = padded;
              out_last_nxt  = 1'b1;
            end
            col_nxt   = '0;
            pbits_nxt = '0;
            pcnt_nxt  = '0;
            state_nxt = S_IDLE;
          end
        end else begin
          col_nxt   = col_r + COL_W'(1);
          pbits_nxt = buf_r[6:0] & pmask[6:0];
          pcnt_nxt  = cnt_r[2:0];
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      pbits_r     <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
      phase_r     <= 1'b0;
      last_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      pbits_r     <= pbits_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    rng_q_r    <= rng_q_nxt;
    val_q_r    <= val_q_nxt;
    buf_r      <= buf_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a column while busy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> cnt_r <= CNT_W'(BUF_W))
    else $error("bit count beyond buffer");

  a_record_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && slot_free && out_valid_nxt && out_last_nxt
      && !(out_valid_r && !out_tready) && cnt_r < CNT_W'(BYTE_W)
    |=> state_r == S_IDLE && col_r == '0 && pcnt_r == '0)
    else $error("record end did not clear the column state");

  a_div_only_for_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> step_r > 16'd1)
    else $error("divider running with step of 0 or 1");
`endif

endmodule

// ===== sim/packed_byte_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_byte_checker
// Watches the config port and both streams of the record column bit packer.
// Every accepted column beat is run through a local packing model and the
// bytes it yields are queued; every accepted output beat is compared with
// the oldest queued byte, data and record end alike.
// ----------------------------------------------------------------------------
module packed_byte_checker
  import rcbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DESC_W-1:0]    cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [VAL_W-1:0]     in_tdata,   // column_value
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [BYTE_W-1:0]    out_tdata,  // out_byte
  input  logic                 out_tlast,  // record_end
  output int                   mismatch_count,
  output int                   bytes_pending,
  output int                   bytes_seen,
  output int                   records_seen
);

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              rec_end;
  } packed_byte_t;

  packed_byte_t     expected_bytes[$];
  logic [COL_W-1:0] col_count_reg;
  col_desc_t        col_desc[MAX_COLUMNS];
  int unsigned      col_index;
  int unsigned      pend_bits;
  int unsigned      pend_count;

  function automatic int unsigned used_bits(input logic [VAL_W-1:0] x);
    int unsigned v;
    int unsigned n;
    v = x;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic logic [VAL_W-1:0] scaled(input col_desc_t d, input logic [VAL_W-1:0] diff);
    if (d.dec && d.step > 1) begin
      return diff / d.step;
    end
    return diff;
  endfunction

  task automatic pack_column(input logic [VAL_W-1:0] value);
    int unsigned      ncols;
    int unsigned      col;
    int unsigned      width;
    int unsigned      field;
    int unsigned      acc;
    int unsigned      count;
    int               n;
    bit               is_last;
    col_desc_t        d;
    logic [VAL_W-1:0] span_q;
    logic [VAL_W-1:0] diff_q;
    packed_byte_t     outs[3];
    ncols = col_count_reg;
    if (ncols == 0) ncols = 1;
    if (ncols > MAX_COLUMNS) ncols = MAX_COLUMNS;
    col = col_index % MAX_COLUMNS;
    is_last = (col + 1) >= ncols;
    d = col_desc[col];
    span_q = d.vmax - d.vmin;
    width = used_bits(scaled(d, span_q));
    diff_q = value - d.vmin;
    field = scaled(d, diff_q) & ((32'd1 << width) - 1);
    acc = ((pend_bits & 32'h7f) << width) | field;
    count = pend_count + width;
    n = 0;
    while (count >= BYTE_W) begin
      count -= BYTE_W;
      outs[n].data = BYTE_W'(acc >> count);
      outs[n].rec_end = 1'b0;
      n++;
    end
    acc = acc & ((32'd1 << count) - 1);
    if (is_last) begin
      if (count > 0) begin
        outs[n].data = BYTE_W'(acc << (BYTE_W - count));
        outs[n].rec_end = 1'b1;
        n++;
      end else if (n > 0) begin
        outs[n-1].rec_end = 1'b1;
      end
      col_index = 0;
      pend_bits = 0;
      pend_count = 0;
    end else begin
      col_index = col + 1;
      pend_bits = acc;
      pend_count = count;
    end
    for (int i = 0; i < n; i++) expected_bytes.push_back(outs[i]);
  endtask

  always @(posedge clk) begin
    packed_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      col_count_reg = COL_W'(1);
      for (int k = 0; k < MAX_COLUMNS; k++) col_desc[k] = '0;
      col_index = 0;
      pend_bits = 0;
      pend_count = 0;
      mismatch_count = 0;
      bytes_seen = 0;
      records_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: no beat expected, actual %h (record_end %b)", out_tdata, out_tlast);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte mismatch: expected %h, actual %h", want.data, out_tdata);
            mismatch_count++;
          end
          if (out_tlast !== want.rec_end) begin
            $error("record_end mismatch: expected %b, actual %b", want.rec_end, out_tlast);
            mismatch_count++;
          end
        end
        bytes_seen++;
        if (out_tlast) records_seen++;
      end
      if (in_tvalid && in_tready) pack_column(in_tdata);
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_COLUMNS) begin
          col_count_reg = cfg_wdata[COL_W-1:0];
        end else if (cfg_index >= CFG_DESC_FIRST && cfg_index <= CFG_DESC_LAST) begin
          col_desc[cfg_index - CFG_DESC_FIRST] = cfg_wdata;
        end
      end
    end
    bytes_pending = expected_bytes.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the record column bit packer. A directed part
// walks the width extremes, the step and decimal cases, record ends on and
// off byte boundaries and column count changes; then randomly configured
// phases stream columns under random stalls on both sides, one long output
// hold-off and drain pauses. The checker module does all the comparing.
// ----------------------------------------------------------------------------
module tb_top;
  import rcbp_pkg::*;

  localparam int SETTLE_CYCLES   = 80;
  localparam int LONG_HOLD       = 250;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_ITEMS    = 230;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DESC_W-1:0]    cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [VAL_W-1:0]     in_tdata;   // column_value
  logic                 out_tvalid;
  logic                 out_tready;
  logic [BYTE_W-1:0]    out_tdata;  // out_byte
  logic                 out_tlast;  // record_end

  int mismatch_count;
  int bytes_pending;
  int bytes_seen;
  int records_seen;

  int        columns_sent;
  int        config_count;
  int        holds_requested;
  int        holds_served;
  int        idle_cycles;
  bit        no_gaps;
  int        tx_stretch;
  bit        tx_busy;
  int        rx_stretch;
  bit        rx_busy;
  col_desc_t cur_desc[MAX_COLUMNS];
  int        cur_ncols;
  int        next_col;

  record_column_bit_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  packed_byte_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .bytes_pending  (bytes_pending),
    .bytes_seen     (bytes_seen),
    .records_seen   (records_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic col_desc_t make_desc(input logic [VAL_W-1:0] vmin, input logic [VAL_W-1:0] vmax,
                                          input logic [VAL_W-1:0] step, input logic dec);
    col_desc_t d;
    d.vmin = vmin;
    d.vmax = vmax;
    d.step = step;
    d.dec = dec;
    return d;
  endfunction

  function automatic col_desc_t rand_desc();
    col_desc_t   d;
    int unsigned w;
    d.vmin = VAL_W'($urandom);
    w = $urandom_range(0, VAL_W);
    d.vmax = d.vmin + ((w == 0) ? VAL_W'(0) : VAL_W'($urandom >> (32 - w)));
    d.dec = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0: d.step = '0;
      1: d.step = VAL_W'(1);
      2: d.step = VAL_W'($urandom_range(2, 9));
      default: d.step = VAL_W'($urandom);
    endcase
    return d;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DESC_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_we <= 1'b0;
    config_count++;
  endtask

  task automatic write_ncols(input logic [DESC_W-1:0] data);
    write_reg(CFG_NUM_COLUMNS, data);
    cur_ncols = (data[COL_W-1:0] == 0) ? 1 : data[COL_W-1:0];
  endtask

  task automatic write_desc(input int k, input col_desc_t d);
    write_reg(CFG_DESC_FIRST + CFG_IDX_W'(k), d);
    cur_desc[k] = d;
  endtask

  task automatic write_ignored();
    write_reg(CFG_DESC_LAST + CFG_IDX_W'($urandom_range(1, 8)), '1);
  endtask

  function automatic int tx_gap();
    if (no_gaps) return 0;
    if (tx_stretch == 0) begin
      tx_stretch = $urandom_range(8, 40);
      tx_busy = $urandom_range(0, 2) != 0;
    end
    tx_stretch--;
    return tx_busy ? $urandom_range(0, 9) : 0;
  endfunction

  task automatic send_column(input logic [VAL_W-1:0] v);
    int gap;
    gap = tx_gap();
    @(negedge clk);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    columns_sent++;
    next_col = (next_col + 1 >= cur_ncols) ? 0 : next_col + 1;
  endtask

  task automatic send_random_column();
    col_desc_t   d;
    int unsigned span;
    d = cur_desc[next_col];
    span = VAL_W'(d.vmax - d.vmin);
    if ($urandom_range(0, 3) == 0) begin
      send_column(VAL_W'($urandom));
    end else begin
      send_column(d.vmin + VAL_W'($urandom % (span + 1)));
    end
  endtask

  task automatic drain(input int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // output side: random back-pressure plus one long hold-off on request
  initial begin
    int gap;
    out_tready = 1'b0;
    holds_served = 0;
    rx_stretch = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (holds_served < holds_requested) begin
        holds_served++;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      if (rx_stretch == 0) begin
        rx_stretch = $urandom_range(8, 40);
        rx_busy = $urandom_range(0, 2) != 0;
      end
      rx_stretch--;
      gap = rx_busy ? $urandom_range(0, 9) : 0;
      repeat (gap) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: %0d cycles without a beat", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int target;
    int phase;
    int count;
    int pause_at;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    columns_sent = 0;
    config_count = 0;
    holds_requested = 0;
    no_gaps = 1'b0;
    tx_stretch = 0;
    cur_ncols = 1;
    next_col = 0;
    for (int k = 0; k < MAX_COLUMNS; k++) cur_desc[k] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one column of width zero, no bytes at all
    send_column(16'h0000);
    send_column(16'hffff);
    drain(SETTLE_CYCLES);

    // 16 + 3 + 7 bits, partial last byte, value below minimum
    write_ncols(3);
    write_desc(0, make_desc(16'h0000, 16'hffff, 16'h0000, 1'b0));
    write_desc(1, make_desc(16'd100, 16'd107, 16'h0000, 1'b0));
    write_desc(2, make_desc(16'd0, 16'd1000, 16'd10, 1'b1));
    cfg_release();
    send_column(16'hffff);
    send_column(16'd50);
    send_column(16'd999);
    send_column(16'h0000);
    send_column(16'd107);
    send_column(16'd1000);
    drain(SETTLE_CYCLES);

    // 24 bits, record ends on a full byte; decimal with step 0 and step 1
    write_desc(0, make_desc(16'h0000, 16'h00ff, 16'h0000, 1'b0));
    write_desc(1, make_desc(16'h0010, 16'h010f, 16'h0000, 1'b1));
    write_desc(2, make_desc(16'hff00, 16'hffff, 16'h0001, 1'b1));
    cfg_release();
    send_column(16'h0000);
    send_column(16'h0010);
    send_column(16'hff00);
    send_column(16'hffff);
    send_column(16'h000f);
    send_column(16'h1234);
    drain(SETTLE_CYCLES);

    // column count of zero acts as one; huge step leaves a single bit
    write_ncols(DESC_W'({$urandom, $urandom}) & ~DESC_W'(7));
    write_desc(0, make_desc(16'h0000, 16'hffff, 16'hffff, 1'b1));
    cfg_release();
    send_column(16'hffff);
    send_column(16'hfffe);
    send_column(16'h0000);
    drain(SETTLE_CYCLES);

    // seven columns, then the count drops below the current column
    write_ncols(7);
    write_desc(0, make_desc(16'h8000, 16'h7fff, 16'h0000, 1'b0));
    write_desc(1, make_desc(16'h0000, 16'h2fff, 16'h0003, 1'b1));
    write_desc(2, make_desc(16'h0100, 16'h011f, 16'h0005, 1'b0));
    write_desc(3, make_desc(16'h0005, 16'h0006, 16'h0000, 1'b0));
    write_desc(4, make_desc(16'h0000, 16'h007f, 16'h0000, 1'b0));
    write_desc(5, rand_desc());
    write_desc(6, '1);
    write_ignored();
    cfg_release();
    send_column(16'h7fff);
    send_column(16'h2ffe);
    send_column(16'h00ff);
    send_column(16'h0006);
    drain(SETTLE_CYCLES);
    write_ncols(2);
    cfg_release();
    send_column(16'h007f);
    send_column(16'hffff);
    send_column(16'h0000);
    drain(SETTLE_CYCLES);

    target = columns_sent + RANDOM_ITEMS;
    phase = 0;
    while (columns_sent < target) begin
      case (phase)
        0: write_ncols(7);
        1: write_ncols(1);
        default: write_ncols($urandom_range(0, MAX_COLUMNS));
      endcase
      for (int k = 0; k < MAX_COLUMNS; k++) begin
        if (phase < 2 || $urandom_range(0, 3) != 0) write_desc(k, rand_desc());
      end
      // hold-off phase: every column yields bytes
      if (phase == 1) write_desc(0, make_desc(16'h0000, 16'hffff, 16'h0000, 1'b0));
      if ($urandom_range(0, 3) == 0) write_ignored();
      cfg_release();
      count = $urandom_range(15, 40);
      pause_at = (phase == 2 || $urandom_range(0, 2) == 0) ? $urandom_range(1, count - 1) : -1;
      if (phase == 1) begin
        holds_requested++;
        no_gaps = 1'b1;
        pause_at = -1;
      end
      for (int i = 0; i < count; i++) begin
        if (i == pause_at) drain(0);
        send_random_column();
      end
      no_gaps = 1'b0;
      drain(SETTLE_CYCLES);
      phase++;
    end

    $display("streamed %0d column beats over %0d register settings", columns_sent, config_count);
    $display("compared %0d packed bytes closing %0d records", bytes_seen, records_seen);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
